// ----- hdl/chol_pkg.sv -----
// Shared types, constants and command/status structs for the Cholesky block.
package chol_pkg;
   localparam int unsigned MaxOrderDefault = 8;
   localparam int unsigned ElemWidth = 32;
   localparam int unsigned SizeWidth = 4;
   localparam logic [SizeWidth-1:0] SizeReset = 4'd4;

   typedef enum logic [2:0] {
      OP_NONE = 3'b001,
      OP_MAC  = 3'b010,
      OP_DIV  = 3'b100
   } dp_op_type;

   typedef struct packed {
      logic       start;
      dp_op_type  op;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
   } dp_sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction
endpackage

// ----- hdl/chol_datapath.sv -----
// Datapath: multiply-subtract, bit-serial square root and divider units.
module chol_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  chol_pkg::dp_cmd_type    cmd,
   input  logic signed [31:0]      opa,
   input  logic signed [31:0]      opb,
   input  logic signed [31:0]      acc,
   output chol_pkg::dp_sts_type    sts,
   output logic signed [31:0]      result
);
   import chol_pkg::*;

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_MUL  = 4'b0010,
      D_SQRT = 4'b0100,
      D_DIV  = 4'b1000
   } dstate_type;

   dstate_type dstate_ff, dstate_in;
   logic signed [63:0] prod_ff;
   logic signed [31:0] acc_ff;
   logic [63:0] rem_ff;
   logic [63:0] root_ff;
   logic [63:0] bit_ff;
   logic [47:0] num_ff;
   logic [31:0] den_ff;
   logic [48:0] quo_ff;
   logic [32:0] drem_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic signed [31:0] result_ff;

   logic [32:0] dtrial;
   logic [48:0] qmag;
   logic signed [65:0] qsig;
   logic signed [63:0] pq;

   assign sts.busy = (dstate_ff != D_IDLE);
   assign result = result_ff;
   assign dtrial = {drem_ff[31:0], num_ff[47]};
   assign qmag = {quo_ff[47:0], (dtrial >= {1'b0, den_ff})};
   assign qsig = neg_ff ? -$signed({17'd0, qmag}) : $signed({17'd0, qmag});
   assign pq = (prod_ff < 0) ? -((-prod_ff) >>> 16) : (prod_ff >>> 16);

   always_comb begin
      dstate_in = dstate_ff;
      unique case (dstate_ff)
         D_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  OP_MAC:  dstate_in = D_MUL;
                  OP_DIV:  dstate_in = D_DIV;
                  default: dstate_in = D_SQRT;
               endcase
            end
         end
         D_MUL:  dstate_in = D_IDLE;
         D_SQRT: if (bit_ff == 64'd0) dstate_in = D_IDLE;
         D_DIV:  if (cnt_ff == 6'd0) dstate_in = D_IDLE;
         default: dstate_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= D_IDLE;
      end else begin
         dstate_ff <= dstate_in;
      end
      unique case (dstate_ff)
         D_IDLE: begin
            prod_ff <= opa * opb;
            acc_ff <= acc;
            rem_ff <= {16'd0, acc[31:0], 16'd0};
            root_ff <= 64'd0;
            bit_ff <= 64'd1 << 46;
            num_ff <= {(acc < 0) ? 32'(-acc) : acc[31:0], 16'd0};
            den_ff <= (opb < 0) ? 32'(-opb) : opb[31:0];
            neg_ff <= acc[31] ^ opb[31];
            quo_ff <= 49'd0;
            drem_ff <= 33'd0;
            cnt_ff <= 6'd47;
         end
         D_MUL: begin
            result_ff <= sat32(66'(acc_ff) - 66'(sat32(66'(pq))));
         end
         D_SQRT: begin
            if (bit_ff != 64'd0) begin
               if (rem_ff >= root_ff + bit_ff) begin
                  rem_ff <= rem_ff - (root_ff + bit_ff);
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end else begin
               result_ff <= root_ff[31:0];
            end
         end
         D_DIV: begin
            drem_ff <= (dtrial >= {1'b0, den_ff}) ? dtrial - {1'b0, den_ff} : dtrial;
            quo_ff <= qmag;
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               result_ff <= (den_ff == 32'd0) ? 32'sd0 : sat32(qsig);
            end
         end
         default: ;
      endcase
   end
endmodule

// ----- hdl/chol_control.sv -----
// Controller: load sequencing, factorization schedule and result streaming.
module chol_control #(
   parameter int unsigned MaxOrder = chol_pkg::MaxOrderDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [3:0]              csr_matrix_size,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_elem_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_l_value,
   output logic                    rsp_failed,
   output logic                    rsp_last,
   output chol_pkg::dp_cmd_type    cmd,
   output logic signed [31:0]      opa,
   output logic signed [31:0]      opb,
   output logic signed [31:0]      acc,
   input  chol_pkg::dp_sts_type    sts,
   input  logic signed [31:0]      result
);
   import chol_pkg::*;

   localparam int unsigned Depth = MaxOrder * MaxOrder;
   localparam int unsigned AW = $clog2(Depth);
   localparam int unsigned IW = $clog2(MaxOrder + 1);

   typedef enum logic [9:0] {
      S_LOAD  = 10'b0000000001,
      S_PIVRD = 10'b0000000010,
      S_PIVOP = 10'b0000000100,
      S_PIVW  = 10'b0000001000,
      S_SQRT  = 10'b0000010000,
      S_ELRD  = 10'b0000100000,
      S_ELOP  = 10'b0001000000,
      S_ELW   = 10'b0010000000,
      S_OUT   = 10'b0100000000,
      S_FAIL  = 10'b1000000000
   } state_type;

   state_type state_ff;
   logic [3:0] size_ff;
   logic [IW-1:0] n;
   logic [AW:0] total;
   logic [AW:0] load_ff;
   logic [IW-1:0] i_ff, j_ff, k_ff;
   logic [1:0] ph_ff;
   logic signed [31:0] mem [Depth];
   logic signed [31:0] rd_ff;
   logic signed [31:0] ta_ff, tb_ff, v_ff, piv_ff;
   logic [AW-1:0] raddr;
   logic [AW:0] oaddr_ff;
   logic [IW-1:0] oi_ff, oj_ff;
   logic out_v_ff, out_upper_ff;
   logic rsp_v_ff, rsp_f_ff, rsp_l_ff;
   logic signed [31:0] rsp_d_ff;
   logic started_ff;
   logic we;
   logic [AW-1:0] waddr;
   logic signed [31:0] wdata;
   logic out_adv;
   logic rsp_fire;

   always_comb begin
      n = (size_ff == 4'd0) ? IW'(1) :
          (32'(size_ff) > MaxOrder) ? IW'(MaxOrder) : IW'(size_ff);
   end
   assign total = (AW+1)'(n) * (AW+1)'(n);

   function automatic logic [AW-1:0] ad(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                        input logic [IW-1:0] nn);
      ad = AW'(r) * AW'(nn) + AW'(c);
   endfunction

   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = rsp_v_ff;
   assign rsp_l_value = rsp_d_ff;
   assign rsp_failed = rsp_f_ff;
   assign rsp_last = rsp_l_ff;
   assign out_adv = !rsp_v_ff || !rsp_stall;
   assign rsp_fire = out_adv && ((state_ff == S_OUT && out_v_ff) || state_ff == S_FAIL);

   // read address: phase 0 reads row i element, the other phases read row j element
   always_comb begin
      raddr = ad(j_ff, j_ff, n);
      if (state_ff == S_OUT) begin
         // hold the issued address while its data waits for the output register
         raddr = oaddr_ff[AW-1:0] - AW'(out_v_ff);
      end else if (ph_ff == 2'd0) begin
         raddr = (k_ff == j_ff) ? ad(i_ff, j_ff, n) : ad(i_ff, k_ff, n);
      end else begin
         raddr = ad(j_ff, k_ff, n);
      end
   end

   always_comb begin
      we = 1'b0;
      waddr = load_ff[AW-1:0];
      wdata = req_elem_value;
      if (state_ff == S_LOAD) begin
         we = req_valid;
      end else if (state_ff == S_SQRT && started_ff && !sts.busy) begin
         we = 1'b1;
         waddr = ad(j_ff, j_ff, n);
         wdata = result;
      end else if (state_ff == S_ELW && started_ff && !sts.busy) begin
         we = 1'b1;
         waddr = ad(i_ff, j_ff, n);
         wdata = result;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // command to datapath
   always_comb begin
      cmd.start = 1'b0;
      cmd.op = OP_MAC;
      opa = ta_ff;
      opb = tb_ff;
      acc = v_ff;
      if (!started_ff) begin
         if (state_ff == S_PIVOP || state_ff == S_ELOP) begin
            cmd.start = 1'b1;
         end else if (state_ff == S_SQRT) begin
            cmd.start = 1'b1;
            cmd.op = OP_NONE;
            acc = piv_ff;
         end else if (state_ff == S_ELW) begin
            cmd.start = 1'b1;
            cmd.op = OP_DIV;
            opb = piv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         size_ff <= SizeReset;
         load_ff <= '0;
         rsp_v_ff <= 1'b0;
         started_ff <= 1'b0;
         out_v_ff <= 1'b0;
         ph_ff <= 2'd0;
      end else begin
         if (out_adv) rsp_v_ff <= rsp_fire;
         if (csr_write) begin
            size_ff <= csr_matrix_size;
            load_ff <= '0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (req_valid && !csr_write) begin
                  if (load_ff + 1'b1 >= total) begin
                     load_ff <= '0;
                     state_ff <= S_PIVRD;
                     j_ff <= '0;
                     i_ff <= '0;
                     k_ff <= '0;
                     ph_ff <= 2'd0;
                  end else begin
                     load_ff <= load_ff + 1'b1;
                  end
               end
            end
            // pivot: v = A[j][j] - sum L[j][k]^2 ; i_ff==j_ff here
            S_PIVRD: begin
               if (ph_ff == 2'd0) begin
                  ph_ff <= 2'd1;
               end else if (ph_ff == 2'd1) begin
                  if (k_ff == j_ff) begin
                     v_ff <= rd_ff;
                     ph_ff <= 2'd0;
                     k_ff <= '0;
                     if (j_ff == '0) begin
                        state_ff <= S_PIVW;
                     end else begin
                        ph_ff <= 2'd2;
                     end
                  end else begin
                     ta_ff <= rd_ff;
                     tb_ff <= rd_ff;
                     state_ff <= S_PIVOP;
                  end
               end else begin
                  ph_ff <= 2'd1;
               end
            end
            S_PIVOP: begin
               started_ff <= 1'b1;
               if (started_ff && !sts.busy) begin
                  started_ff <= 1'b0;
                  v_ff <= result;
                  k_ff <= k_ff + 1'b1;
                  ph_ff <= 2'd2;
                  if (k_ff + 1'b1 == j_ff) state_ff <= S_PIVW;
                  else state_ff <= S_PIVRD;
               end
            end
            S_PIVW: begin
               if (v_ff <= 0) begin
                  state_ff <= S_FAIL;
               end else begin
                  piv_ff <= v_ff;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               started_ff <= 1'b1;
               if (started_ff && !sts.busy) begin
                  started_ff <= 1'b0;
                  piv_ff <= result;
                  if (j_ff + 1'b1 >= n) begin
                     state_ff <= S_OUT;
                     oaddr_ff <= '0;
                     oi_ff <= '0;
                     oj_ff <= '0;
                     out_v_ff <= 1'b0;
                  end else begin
                     i_ff <= j_ff + 1'b1;
                     k_ff <= j_ff;
                     ph_ff <= 2'd0;
                     state_ff <= S_ELRD;
                  end
               end
            end
            // element: read A[i][j] (k==j first), then pairs (L[i][k], L[j][k])
            S_ELRD: begin
               if (ph_ff == 2'd0) begin
                  ph_ff <= 2'd1;
               end else if (ph_ff == 2'd1) begin
                  if (k_ff == j_ff) begin
                     v_ff <= rd_ff;
                     k_ff <= '0;
                     ph_ff <= 2'd0;
                     if (j_ff == '0) state_ff <= S_ELW;
                  end else begin
                     ta_ff <= rd_ff;
                     ph_ff <= 2'd2;
                  end
               end else if (ph_ff == 2'd2) begin
                  ph_ff <= 2'd3;
               end else begin
                  tb_ff <= rd_ff;
                  state_ff <= S_ELOP;
               end
            end
            S_ELOP: begin
               started_ff <= 1'b1;
               if (started_ff && !sts.busy) begin
                  started_ff <= 1'b0;
                  v_ff <= result;
                  k_ff <= k_ff + 1'b1;
                  ph_ff <= 2'd0;
                  if (k_ff + 1'b1 == j_ff) state_ff <= S_ELW;
                  else state_ff <= S_ELRD;
               end
            end
            S_ELW: begin
               started_ff <= 1'b1;
               if (started_ff && !sts.busy) begin
                  started_ff <= 1'b0;
                  ph_ff <= 2'd0;
                  if (i_ff + 1'b1 >= n) begin
                     // next column starts with its diagonal read
                     j_ff <= j_ff + 1'b1;
                     i_ff <= j_ff + 1'b1;
                     k_ff <= j_ff + 1'b1;
                     state_ff <= S_PIVRD;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                     k_ff <= j_ff;
                     state_ff <= S_ELRD;
                  end
               end
            end
            // stream: address issued, data registered in rd_ff, then moved to the output register
            S_OUT: begin
               if (out_adv) begin
                  if (out_v_ff) begin
                     rsp_d_ff <= out_upper_ff ? 32'sd0 : rd_ff;
                     rsp_f_ff <= 1'b0;
                     rsp_l_ff <= (oaddr_ff == total);
                     out_v_ff <= 1'b0;
                     if (oaddr_ff == total) state_ff <= S_LOAD;
                  end else begin
                     out_v_ff <= 1'b1;
                     out_upper_ff <= (oj_ff > oi_ff);
                     oaddr_ff <= oaddr_ff + 1'b1;
                     if (oj_ff + 1'b1 >= n) begin
                        oj_ff <= '0;
                        oi_ff <= oi_ff + 1'b1;
                     end else begin
                        oj_ff <= oj_ff + 1'b1;
                     end
                  end
               end
            end
            S_FAIL: begin
               if (out_adv) begin
                  rsp_d_ff <= 32'sd0;
                  rsp_f_ff <= 1'b1;
                  rsp_l_ff <= 1'b1;
                  state_ff <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end
endmodule

// ----- hdl/cholesky_factorization.sv -----
// Top level of the Q16.16 Cholesky factorization block.
//
// Usage: write csr_matrix_size (order 1..MaxOrder; 0 acts as 1, larger
// values clamp) with csr_write while idle; this also restarts loading.
// Send n*n requests of req_elem_value, row-major, on req_valid/req_stall,
// one per cycle. Only the lower triangle (diagonal included) is used.
// After the last request the block stalls its input and factors in place:
// per column, the pivot takes a diagonal read, a multiply-subtract per
// product and a sign test, then the bit-serial square root; each
// element below the pivot takes its read, a multiply-subtract per product
// and the 48-step restoring divider, all on the shared datapath.
// Results stream out row by row on rsp_valid/rsp_stall; rsp_last marks
// the final one. A pivot that is not positive yields a single result
// with rsp_failed set. A stalled result holds in its output register.
// Synchronous reset returns to loading with order 4; stored matrix
// contents are not cleared.
module cholesky_factorization #(
   parameter int unsigned MaxOrder = chol_pkg::MaxOrderDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [3:0]          csr_matrix_size,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_elem_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_l_value,
   output logic                rsp_failed,
   output logic                rsp_last
);
   import chol_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic signed [31:0] opa, opb, acc, result;

   // controller: sequencing, memory and result register
   chol_control #(.MaxOrder(MaxOrder)) u_ctrl (
      .clock, .reset, .csr_write, .csr_matrix_size,
      .req_valid, .req_stall, .req_elem_value,
      .rsp_valid, .rsp_stall, .rsp_l_value, .rsp_failed, .rsp_last,
      .cmd, .opa, .opb, .acc, .sts, .result
   );

   // datapath: multiply-subtract, root and divide units
   chol_datapath u_dp (
      .clock, .reset, .cmd, .opa, .opb, .acc, .sts, .result
   );
endmodule

// ----- hdl/chol_checker.sv -----
// Port-level checker for the Cholesky block and its bind.
module chol_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_l_value,
   input logic        rsp_failed,
   input logic        rsp_last
);
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_last) else $error("fail without last");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_l_value == 32'd0) else $error("fail value");
   a_no_load_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall) else $error("load during output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_l_value))
      else $error("stalled result changed");
endmodule

bind cholesky_factorization chol_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_l_value, .rsp_failed, .rsp_last
);

// ----- sim/tb_cholesky_factorization.sv -----
// Self-checking testbench for the Q16.16 Cholesky factorization block.
module tb_cholesky_factorization;
   import chol_pkg::*;

   localparam int unsigned MaxN = MaxOrderDefault;
   localparam int unsigned StallLimit = 20000;
   localparam int unsigned HoldCycles = 400;
   localparam int unsigned ItemTarget = 230;

   typedef struct {
      logic signed [31:0] l_value;
      logic failed;
      logic last;
   } l_elem_type;

   // Scoreboard: keeps its own copy of the block's state, factors each
   // completed matrix and queues the elements of L that must come out.
   class chol_scoreboard;
      logic [3:0] size_reg;
      logic signed [31:0] store [64];
      int unsigned loaded;
      l_elem_type factor_q [$];
      int unsigned mismatches;
      int unsigned results_seen;
      int unsigned failed_seen;

      function new();
         size_reg = SizeReset;
         loaded = 0;
         mismatches = 0;
         results_seen = 0;
         failed_seen = 0;
      endfunction

      function void set_size(logic [3:0] s);
         size_reg = s;
         loaded = 0;
      endfunction

      function int unsigned order();
         if (size_reg == 0) return 1;
         if (size_reg > MaxN) return MaxN;
         return size_reg;
      endfunction

      function logic signed [31:0] clip(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
         longint p;
         p = longint'(a) * longint'(b);
         return clip(p / 65536);
      endfunction

      function logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] p);
         if (p == 0) return 0;
         return clip((longint'(a) * 65536) / longint'(p));
      endfunction

      function logic signed [31:0] fx_sqrt(logic signed [31:0] v);
         longint unsigned x, r, b;
         x = longint'(unsigned'(v)) * 65536;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r[31:0];
      endfunction

      // Note one accepted request; on the last element, factor and queue L.
      function void note_request(logic signed [31:0] v);
         int unsigned n, i, j, k;
         logic signed [31:0] piv, acc;
         l_elem_type e;
         n = order();
         if (loaded >= n * n) loaded = 0;
         store[loaded] = v;
         loaded++;
         if (loaded < n * n) return;
         loaded = 0;
         for (j = 0; j < n; j++) begin
            piv = store[j*n+j];
            for (k = 0; k < j; k++)
               piv = clip(longint'(piv) - longint'(fx_mul(store[j*n+k], store[j*n+k])));
            if (piv <= 0) begin
               e.l_value = 0; e.failed = 1; e.last = 1;
               factor_q.push_back(e);
               return;
            end
            piv = fx_sqrt(piv);
            store[j*n+j] = piv;
            for (i = j + 1; i < n; i++) begin
               acc = store[i*n+j];
               for (k = 0; k < j; k++)
                  acc = clip(longint'(acc)
                             - longint'(fx_mul(store[i*n+k], store[j*n+k])));
               store[i*n+j] = fx_div(acc, piv);
            end
         end
         for (i = 0; i < n * n; i++) begin
            e.l_value = ((i % n) > (i / n)) ? 32'sd0 : store[i];
            e.failed = 0;
            e.last = (i + 1 == n * n);
            factor_q.push_back(e);
         end
      endfunction

      function void check_result(logic signed [31:0] l, logic f, logic lst);
         l_elem_type e;
         results_seen++;
         if (f) failed_seen++;
         if (factor_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: l=%h failed=%0d last=%0d", l, f, lst);
            return;
         end
         e = factor_q.pop_front();
         if (e.l_value !== l || e.failed !== f || e.last !== lst) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected l=%h failed=%0d last=%0d, got l=%h failed=%0d last=%0d",
                        e.l_value, e.failed, e.last, l, f, lst);
         end
      endfunction

      function int unsigned pending();
         return factor_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write;
   logic [3:0] csr_matrix_size;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_elem_value;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_l_value;
   logic rsp_failed;
   logic rsp_last;

   chol_scoreboard sb;
   int unsigned requests_sent;
   int unsigned matrices_sent;
   int unsigned quiet_cycles;
   bit hold_req;

   cholesky_factorization dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_matrix_size(csr_matrix_size),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_elem_value(req_elem_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_l_value(rsp_l_value),
      .rsp_failed(rsp_failed),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Offer one request and hold it until the block takes it.
   task automatic send_elem(logic signed [31:0] v);
      @(negedge clock);
      req_valid <= 1;
      req_elem_value <= v;
      do @(posedge clock); while (req_stall);
      sb.note_request(v);
      requests_sent++;
   endtask

   // Drop valid for a random gap now and then, so bursts have random length.
   task automatic maybe_gap();
      int unsigned g;
      if ($urandom_range(0, 3) != 0) return;
      g = $urandom_range(1, 6);
      @(negedge clock);
      req_valid <= 0;
      repeat (g - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      // let any trailing activity settle before touching the register
      repeat (10) @(posedge clock);
   endtask

   task automatic write_size(logic [3:0] s);
      @(negedge clock);
      csr_write <= 1;
      csr_matrix_size <= s;
      @(negedge clock);
      csr_write <= 0;
      sb.set_size(s);
   endtask

   // Send one matrix. Kind 0: well formed SPD built as L*L^T with integer L
   // and random fraction bits; kind 1: pure noise; kind 2: SPD with one
   // diagonal element made zero or negative so the factorization fails there.
   task automatic send_matrix(int unsigned kind);
      int unsigned n, i, j, k, bad;
      int lint [MaxN][MaxN];
      longint a;
      n = sb.order();
      bad = $urandom_range(0, n - 1);
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++)
            lint[i][j] = (j > i) ? 0 : (i == j) ? $urandom_range(1, 8)
                                                 : $urandom_range(0, 8) - 4;
      for (i = 0; i < n; i++) begin
         for (j = 0; j < n; j++) begin
            if (kind == 1 || j > i) begin
               send_elem($urandom);
            end else begin
               a = 0;
               for (k = 0; k < n; k++) a += lint[i][k] * lint[j][k];
               a = (a << 16) + $urandom_range(0, 255);
               if (kind == 2 && i == bad && j <= i) a = (j == i) ? 0 : a;
               if (kind == 2 && i == bad && j == i) a = -$urandom_range(0, 65536);
               send_elem(a[31:0]);
            end
            maybe_gap();
         end
      end
      matrices_sent++;
   endtask

   // Receiver: stall on its own pattern; hold off for a long stretch on request.
   initial begin
      int unsigned mode, left;
      rsp_stall = 0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1;
            repeat (HoldCycles - 1) @(negedge clock);
            hold_req = 0;
            rsp_stall <= 0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Check results and run the watchdog on the rising edge.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall)
               sb.check_result(rsp_l_value, rsp_failed, rsp_last);
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_write)
               quiet_cycles = 0;
            else
               quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
               $display("timeout: no handshake for %0d cycles", StallLimit);
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   initial begin
      int unsigned kind;
      logic [3:0] s;
      bit held;
      sb = new();
      requests_sent = 0;
      matrices_sent = 0;
      hold_req = 0;
      held = 0;
      reset = 1;
      csr_write = 0;
      csr_matrix_size = SizeReset;
      req_valid = 0;
      req_elem_value = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: order one with the field extremes, tiny and failing pivots.
      write_size(4'd1);
      send_elem(32'sh7fffffff);
      send_elem(32'sh00000001);
      send_elem(32'sh80000000);
      send_elem(32'sh00000000);
      drain();
      // Order two with saturating values.
      write_size(4'd2);
      send_elem(32'sh7fffffff); send_elem(32'sh80000000);
      send_elem(32'sh7fffffff); send_elem(32'sh7fffffff);
      drain();
      // Register write mid-load restarts loading.
      write_size(4'd2);
      send_elem(32'sh00010000); send_elem(32'sh00020000);
      drain();
      write_size(4'd0);  // acts as order one
      send_elem(32'sh00040000);
      drain();
      write_size(4'd2);
      send_matrix(2);
      drain();

      // Random: mostly well formed matrices of small order.
      while (requests_sent < ItemTarget) begin
         if (matrices_sent == 8) s = 4'd15;            // clamps to the maximum
         else if (matrices_sent == 14) s = 4'd8;
         else if ($urandom_range(0, 4) == 0) s = 4'($urandom_range(0, 6));
         else s = 4'($urandom_range(2, 4));
         write_size(s);
         if (!held && matrices_sent >= 5) begin
            // Long receiver hold-off while the sender keeps offering.
            held = 1;
            hold_req = 1;
            repeat (3) send_matrix(0);
         end else begin
            kind = $urandom_range(0, 9);
            kind = (kind < 7) ? 0 : (kind < 9) ? 1 : 2;
            send_matrix(kind);
            if ($urandom_range(0, 2) == 0) send_matrix(0);
         end
         drain();
      end

      drain();
      repeat (50) @(posedge clock);
      if (sb.pending() != 0) sb.mismatches++;
      $display("covered %0d requests in %0d matrices, %0d results checked (%0d failed runs)",
               requests_sent, matrices_sent, sb.results_seen, sb.failed_seen);
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
